// ----- rtl/rgbpa_pkg.sv -----
// ============================================================================
// rgbpa_pkg
// Shared types and codes of the RGB pixel arithmetic unit: pixel and result
// payloads, operation codes, register indexes and pipeline depth.
// ============================================================================
package rgbpa_pkg;

    // Pipeline depth, input register to output register
    localparam int NUM_STAGES = 5;

    // Configuration register indexes
    localparam logic [2:0] REG_OPERATION   = 3'd0;
    localparam logic [2:0] REG_USE_CONST   = 3'd1;
    localparam logic [2:0] REG_CONST_RED   = 3'd2;
    localparam logic [2:0] REG_CONST_GREEN = 3'd3;
    localparam logic [2:0] REG_CONST_BLUE  = 3'd4;

    // Operation codes; the unused code passes the source pixel through
    typedef enum logic [2:0] {
        OP_ABSDIFF = 3'd0,
        OP_ADD     = 3'd1,
        OP_MUL     = 3'd2,
        OP_REM     = 3'd3,
        OP_DIV     = 3'd4,
        OP_MAX     = 3'd5,
        OP_MIN     = 3'd6
    } op_t;

    // Control settings shared by all three channel pipelines
    typedef struct packed {
        op_t  op;
        logic use_const;
    } ctl_t;

    // Input pixel pair
    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] opd_red;
        logic [7:0] opd_green;
        logic [7:0] opd_blue;
    } pix_t;

    // Result pixel
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } res_t;

endpackage

// ----- rtl/rgbpa_channel.sv -----
// ============================================================================
// rgbpa_channel
// Five-stage datapath for one color channel. Stage 1 selects the operand,
// does the simple operations and the multiply, and sets up the divider.
// Stage 2 scales the product; stages 2 to 5 run a restoring divider two
// quotient bits per stage; stage 5 is the output register.
// ============================================================================
module rgbpa_channel (
    input  logic                                clk,
    input  logic [rgbpa_pkg::NUM_STAGES-1:0]    adv,
    input  rgbpa_pkg::ctl_t                     ctl,
    input  logic signed [15:0]                  cval,
    input  logic [7:0]                          src,
    input  logic [7:0]                          opd,
    output logic [7:0]                          res
);

    localparam int MID = rgbpa_pkg::NUM_STAGES - 1;

    typedef struct packed {
        logic [17:0]        r;       // partial remainder / dividend
        logic [16:0]        dv;      // divisor
        logic [7:0]         q;       // quotient bits so far
        logic               sat;     // quotient would reach 256
        logic               early;   // divide with divisor <= 0
        logic [7:0]         simple;  // result of the simple operations
        logic signed [24:0] prod;    // a * b
        logic [7:0]         mul;     // product scaled by 1/255
    } stg_t;

    stg_t       st_reg  [MID];
    stg_t       st_next [MID];
    logic [7:0] res_reg;
    logic [7:0] res_next;

    // Clamp a signed value to 0..255
    function automatic logic [7:0] clamp8(logic signed [16:0] v);
        if (v < 17'sd0)
            return 8'd0;
        else if (v > 17'sd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [18:0] div_step(logic [17:0] r, logic [16:0] dv,
                                             logic [2:0] sh);
        logic [24:0] sd;
        logic [24:0] rr;
        sd = {8'b0, dv} << sh;
        rr = {7'b0, r};
        if (rr >= sd)
            return {1'b1, 18'(rr - sd)};
        else
            return {1'b0, r};
    endfunction

    // Two quotient bits, highest shift first
    function automatic stg_t two_steps(stg_t s, logic [2:0] sh_hi);
        stg_t        o;
        logic [18:0] t;
        o = s;
        t = div_step(o.r, o.dv, sh_hi);
        o.r = t[17:0];
        o.q[sh_hi] = t[18];
        t = div_step(o.r, o.dv, sh_hi - 3'd1);
        o.r = t[17:0];
        o.q[sh_hi - 3'd1] = t[18];
        return o;
    endfunction

    // Stage 1: operand select, simple operations, multiply, divider setup
    always_comb
    begin
        logic signed [16:0] a_s;
        logic signed [16:0] b_s;
        logic signed [16:0] diff;
        logic signed [16:0] mag;
        logic signed [16:0] d;
        logic [16:0]        m;
        a_s  = $signed({9'b0, src});
        b_s  = ctl.use_const ? {cval[15], cval} : $signed({9'b0, opd});
        diff = a_s - b_s;
        mag  = (diff < 17'sd0) ? -diff : diff;
        d    = b_s + 17'sd1;
        m    = (b_s < 17'sd0) ? 17'(-b_s) : 17'(b_s);

        st_next[0]       = '0;
        st_next[0].prod  = 25'(a_s) * 25'(b_s);
        st_next[0].r     = 18'(src);
        st_next[0].dv    = (m == 17'd0) ? 17'd1 : m;
        st_next[0].simple = src;

        case (ctl.op)
            rgbpa_pkg::OP_ABSDIFF: st_next[0].simple = clamp8(mag);
            rgbpa_pkg::OP_ADD:     st_next[0].simple = clamp8(a_s + b_s);
            rgbpa_pkg::OP_MAX:     st_next[0].simple = clamp8((a_s > b_s) ? a_s : b_s);
            rgbpa_pkg::OP_MIN:     st_next[0].simple = clamp8((a_s < b_s) ? a_s : b_s);
            rgbpa_pkg::OP_DIV:
            begin
                // dividend 510a + d, divisor 2d gives a*255/d rounded half up
                st_next[0].r      = 18'(src) * 18'd510 + 18'(d[15:0]);
                st_next[0].dv     = {d[15:0], 1'b0};
                st_next[0].early  = (d <= 17'sd0);
                st_next[0].simple = (src == 8'd0) ? 8'd0 : 8'd255;
            end
            default: ;
        endcase
    end

    // Stage 2: scale product by 1/255, overflow check, quotient bits 7 and 6
    always_comb
    begin
        logic [15:0] t;
        stg_t        s;
        s = st_reg[0];
        t = s.prod[15:0] + 16'd1 + {8'b0, s.prod[15:8]};
        if (s.prod <= 25'sd0)
            s.mul = 8'd0;
        else if (s.prod >= 25'sd65280)
            s.mul = 8'd255;
        else
            s.mul = t[15:8];
        s.sat = ({7'b0, s.r} >= {s.dv, 8'b0});
        st_next[1] = two_steps(s, 3'd7);
    end

    // Stages 3 and 4: quotient bits 5..2
    always_comb
    begin
        st_next[2] = two_steps(st_reg[1], 3'd5);
        st_next[3] = two_steps(st_reg[2], 3'd3);
    end

    // Stage 5: quotient bits 1 and 0, result select
    always_comb
    begin
        stg_t s;
        s = two_steps(st_reg[MID-1], 3'd1);
        case (ctl.op)
            rgbpa_pkg::OP_MUL: res_next = s.mul;
            rgbpa_pkg::OP_REM: res_next = s.r[7:0];
            rgbpa_pkg::OP_DIV:
            begin
                if (s.early)
                    res_next = s.simple;
                else if (s.sat)
                    res_next = 8'd255;
                else
                    res_next = s.q;
            end
            default:           res_next = s.simple;
        endcase
    end

    // Stage registers, each loaded when its stage advances
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MID; i++)
        begin
            if (adv[i])
                st_reg[i] <= st_next[i];
        end
        if (adv[MID])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/rgb_pixel_arithmetic_unit.sv -----
// ============================================================================
// rgb_pixel_arithmetic_unit
// Per-pixel RGB arithmetic against a second pixel or a constant color.
// ============================================================================
// Usage:
//   pix channel: one request carries a source pixel and a second pixel.
//   res channel: one result pixel per request, in request order.
//   cfg channel: register index and data; always ready. Write only while
//   the pipeline is empty. Unknown indexes are ignored.
// Throughput: one pixel per cycle while pix_ready stays high. The pipeline
//   depth comes from the restoring divider of divide and remainder, which
//   resolves two quotient bits per stage.
// Stall: when res_ready is low the pipeline keeps moving until its bubbles
//   are filled; pix_ready drops only once every stage holds a pixel.
//   Nothing is lost or repeated.
// Reset: clears all stage valid bits and sets the registers to operation
//   absdiff, second-pixel operand and a zero constant color.
// ============================================================================
module rgb_pixel_arithmetic_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  rgbpa_pkg::pix_t     pix,
    output logic                res_valid,
    input  logic                res_ready,
    output rgbpa_pkg::res_t     res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int NS = rgbpa_pkg::NUM_STAGES;

    rgbpa_pkg::op_t     op_reg;
    logic               use_const_reg;
    logic signed [15:0] const_reg [3];
    rgbpa_pkg::ctl_t    ctl;

    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      v_next;
    logic [NS-1:0]      adv;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= rgbpa_pkg::OP_ABSDIFF;
            use_const_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                const_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbpa_pkg::REG_OPERATION:   op_reg <= rgbpa_pkg::op_t'(cfg_data[2:0]);
                rgbpa_pkg::REG_USE_CONST:   use_const_reg <= cfg_data[0];
                rgbpa_pkg::REG_CONST_RED:   const_reg[0] <= cfg_data;
                rgbpa_pkg::REG_CONST_GREEN: const_reg[1] <= cfg_data;
                rgbpa_pkg::REG_CONST_BLUE:  const_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl.op        = op_reg;
    assign ctl.use_const = use_const_reg;

    // Stage advance: a stage moves when empty or when the one after moves
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || res_ready;
        for (int i = NS - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
            v_next[0] = pix_valid;
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
                v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign pix_ready = adv[0];
    assign res_valid = v_reg[NS-1];

    // Channel datapaths
    rgbpa_channel u_red (
        .clk  (clk),
        .adv  (adv),
        .ctl  (ctl),
        .cval (const_reg[0]),
        .src  (pix.src_red),
        .opd  (pix.opd_red),
        .res  (res.out_red)
    );

    rgbpa_channel u_green (
        .clk  (clk),
        .adv  (adv),
        .ctl  (ctl),
        .cval (const_reg[1]),
        .src  (pix.src_green),
        .opd  (pix.opd_green),
        .res  (res.out_green)
    );

    rgbpa_channel u_blue (
        .clk  (clk),
        .adv  (adv),
        .ctl  (ctl),
        .cval (const_reg[2]),
        .src  (pix.src_blue),
        .opd  (pix.opd_blue),
        .res  (res.out_blue)
    );

endmodule

// ----- rtl/rgbpa_checker.sv -----
// ============================================================================
// rgbpa_checker
// Port-level checks of the RGB pixel arithmetic unit, bound to the top level.
// ============================================================================
module rgbpa_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    input  logic            pix_ready,
    input  logic            res_valid,
    input  logic            res_ready,
    input  rgbpa_pkg::res_t res
);

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    // A free receiver never back-pressures the source
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> pix_ready)
        else $error("pix_ready low while res_ready high");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    // Accepted request yields a valid result with the receiver always ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready && res_ready) ##1 res_ready ##1 res_ready
            ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("result missing five cycles after request");

endmodule

bind rgb_pixel_arithmetic_unit rgbpa_checker u_rgbpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
